@@ design/cssc_pkg.sv @@
package cssc_pkg;

   // Field widths of the channels
   localparam int CH_W        = 8;
   localparam int REG_W       = 4;
   localparam int OUT_SLOT_W  = 10;
   localparam int OUT_BYTE_W  = 16;
   localparam int CHAR_W      = 12;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 4;
   localparam int SLOT_ADD_W  = 2;
   localparam int BYTE_ADD_W  = 6;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEC_LIMIT = 4'd1;
   localparam logic [REG_W-1:0]     INT_LIMIT_RST = 4'd6;
   localparam logic [REG_W-1:0]     VEC_LIMIT_RST = 4'd8;

   localparam logic [CHAR_W-1:0]    CHAR_MAX = 12'hFFF;

   // Characters with a structural role
   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CH_W-1:0] CH_PTR    = 8'h50;
   localparam logic [CH_W-1:0] CH_XSKIP  = 8'h58;
   localparam logic [CH_W-1:0] CH_CPLX   = 8'h43;
   localparam logic [CH_W-1:0] CH_VEC    = 8'h47;
   localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LOW_Z  = 8'h7A;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_AFTER_P,
      MODE_SKIP,
      MODE_AFTER_C,
      MODE_AFTER_G
   } mode_type;

   // What one character does to the running counts
   typedef struct packed {
      logic                  is_end;
      logic                  count_char;
      logic                  int_inc;
      logic                  vec_inc;
      logic [SLOT_ADD_W-1:0] slot_add;
      logic [BYTE_ADD_W-1:0] byte_add;
      mode_type              next_mode;
   } action_type;

   // Byte size added by the character after a 'C' or 'G' prefix
   function automatic logic [BYTE_ADD_W-1:0] prefix_size(input logic is_g,
                                                         input logic [CH_W-1:0] c);
      logic [BYTE_ADD_W-1:0] size;
      size = '0;
      case (c)
         "f":     size = is_g ? 6'd4  : 6'd8;
         "d":     size = is_g ? 6'd8  : 6'd16;
         "e":     size = is_g ? 6'd12 : 6'd32;
         "g":     size = is_g ? 6'd16 : 6'd32;
         "k":     size = 6'd4;
         default: size = '0;
      endcase
      return size;
   endfunction

endpackage

@@ design/cssc_req_if.sv @@
interface cssc_req_if import cssc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

@@ design/cssc_rsp_if.sv @@
interface cssc_rsp_if import cssc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REG_W-1:0]      int_regs;
   logic [REG_W-1:0]      vec_regs;
   logic [OUT_SLOT_W-1:0] stack_slots;
   logic [OUT_BYTE_W-1:0] extra_bytes;
   logic [CHAR_W-1:0]     chars_used;

   modport source (output valid, output int_regs, output vec_regs, output stack_slots,
                   output extra_bytes, output chars_used, input ready);
   modport sink (input valid, input int_regs, input vec_regs, input stack_slots,
                 input extra_bytes, input chars_used, output ready);
endinterface

@@ design/cssc_csr_if.sv @@
interface cssc_csr_if import cssc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/cssc_decode.sv @@
module cssc_decode import cssc_pkg::*; (
   input  logic [CH_W-1:0] ch,
   input  mode_type        mode,
   input  logic            int_room,
   input  logic            vec_room,
   input  logic            slot_odd,
   output action_type      act
);

   logic is_lower;
   logic do_normal;

   assign is_lower = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);

   // Pick the path through the current parse mode
   always_comb begin
      act            = '0;
      act.next_mode  = mode;
      act.count_char = (ch != CH_NUL);
      do_normal      = 1'b0;
      if (ch == CH_NUL) begin
         act.is_end = 1'b1;
      end else begin
         case (mode)
            MODE_AFTER_P: begin
               if (ch == CH_PTR) begin
                  act.next_mode = MODE_AFTER_P;
               end else if (is_lower) begin
                  act.next_mode = MODE_NORMAL;
               end else if (ch == CH_XSKIP) begin
                  act.next_mode = MODE_SKIP;
               end else if (ch == CH_RPAREN) begin
                  act.is_end = 1'b1;
               end else begin
                  act.next_mode = MODE_NORMAL;
                  do_normal     = 1'b1;
               end
            end
            MODE_SKIP: begin
               if (ch == CH_SEMI) begin
                  act.next_mode = MODE_NORMAL;
               end
            end
            MODE_AFTER_C: begin
               act.byte_add  = prefix_size(1'b0, ch);
               act.next_mode = MODE_NORMAL;
            end
            MODE_AFTER_G: begin
               act.byte_add  = prefix_size(1'b1, ch);
               act.next_mode = MODE_NORMAL;
            end
            default: begin
               if (ch == CH_RPAREN) begin
                  act.is_end = 1'b1;
               end else begin
                  do_normal = 1'b1;
               end
            end
         endcase
      end

      // Classify one argument letter
      if (do_normal) begin
         case (ch)
            "a", "b", "c", "h", "s", "t", "w", "i", "j", "l", "m", "x", "y", "r": begin
               act.int_inc  = int_room;
               act.slot_add = int_room ? 2'd0 : 2'd1;
            end
            CH_PTR: begin
               act.int_inc   = int_room;
               act.slot_add  = int_room ? 2'd0 : 2'd1;
               act.next_mode = MODE_AFTER_P;
            end
            "d", "f", "k": begin
               act.vec_inc  = vec_room;
               act.slot_add = vec_room ? 2'd0 : 2'd1;
            end
            "e", "g", "n", "o": begin
               // round up to an even slot, then take two
               act.vec_inc  = vec_room;
               act.slot_add = vec_room ? 2'd0 : (slot_odd ? 2'd3 : 2'd2);
            end
            CH_CPLX: begin
               act.next_mode = MODE_AFTER_C;
            end
            CH_VEC: begin
               act.next_mode = MODE_AFTER_G;
            end
            default: begin
               act.slot_add = 2'd0;
            end
         endcase
      end
   end

endmodule

@@ design/call_signature_slot_classifier_unit.sv @@
// A result appears in the cycle after the word that ends a signature is taken.
// Throughput: one character word per cycle unless a result waits; each word updates
// the counters in a single pass of decode and saturating adds ahead of the state
// registers. Reset (synchronous): counters clear, parse mode returns to normal,
// the output register empties, register limits return to 6 integer and 8 vector.
module call_signature_slot_classifier_unit import cssc_pkg::*; #(
   parameter int SLOT_BITS = 10,
   parameter int BYTE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cssc_req_if.sink   req_port,
   cssc_rsp_if.source rsp_port,
   cssc_csr_if.sink   csr_port
);

   localparam logic [SLOT_BITS-1:0] SLOT_MAX = {SLOT_BITS{1'b1}};
   localparam logic [BYTE_BITS-1:0] BYTE_MAX = {BYTE_BITS{1'b1}};

   logic [REG_W-1:0]      int_limit_ff;
   logic [REG_W-1:0]      vec_limit_ff;

   mode_type              mode_ff, mode_in;
   logic [REG_W-1:0]      int_ff, int_in;
   logic [REG_W-1:0]      vec_ff, vec_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [BYTE_BITS-1:0]  byte_ff, byte_in;
   logic [CHAR_W-1:0]     char_ff, char_in;

   logic                  rsp_valid_ff;
   logic [REG_W-1:0]      rsp_int_ff;
   logic [REG_W-1:0]      rsp_vec_ff;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff;
   logic [OUT_BYTE_W-1:0] rsp_byte_ff;
   logic [CHAR_W-1:0]     rsp_char_ff;

   action_type            act;
   logic                  req_take;
   logic [SLOT_BITS:0]    slot_sum;
   logic [BYTE_BITS:0]    byte_sum;
   logic [SLOT_BITS+OUT_SLOT_W-1:0] slot_wide;
   logic [BYTE_BITS+OUT_BYTE_W-1:0] byte_wide;

   // Configuration writes
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_limit_ff <= INT_LIMIT_RST;
         vec_limit_ff <= VEC_LIMIT_RST;
      end else if (csr_port.valid) begin
         if (csr_port.index == REG_INT_LIMIT) begin
            int_limit_ff <= csr_port.data;
         end else if (csr_port.index == REG_VEC_LIMIT) begin
            vec_limit_ff <= csr_port.data;
         end
      end
   end

   // Decode the character
   cssc_decode u_decode (
      .ch       (req_port.ch),
      .mode     (mode_ff),
      .int_room (int_ff < int_limit_ff),
      .vec_room (vec_ff < vec_limit_ff),
      .slot_odd (slot_ff[0]),
      .act      (act)
   );

   // Take a word whenever the output register is free or draining
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_take       = req_port.valid && req_port.ready;

   // Saturating counter updates
   assign slot_sum = {1'b0, slot_ff} + {{(SLOT_BITS-1){1'b0}}, act.slot_add};
   assign byte_sum = {1'b0, byte_ff} + {{(BYTE_BITS-5){1'b0}}, act.byte_add};

   always_comb begin
      mode_in = act.next_mode;
      int_in  = int_ff + {{(REG_W-1){1'b0}}, act.int_inc};
      vec_in  = vec_ff + {{(REG_W-1){1'b0}}, act.vec_inc};
      slot_in = slot_sum[SLOT_BITS] ? SLOT_MAX : slot_sum[SLOT_BITS-1:0];
      byte_in = byte_sum[BYTE_BITS] ? BYTE_MAX : byte_sum[BYTE_BITS-1:0];
      char_in = char_ff;
      if (act.count_char && (char_ff != CHAR_MAX)) begin
         char_in = char_ff + 12'd1;
      end
   end

   // Hold the parse state, clear it when a signature ends
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         int_ff  <= '0;
         vec_ff  <= '0;
         slot_ff <= '0;
         byte_ff <= '0;
         char_ff <= '0;
      end else if (req_take) begin
         if (act.is_end) begin
            mode_ff <= MODE_NORMAL;
            int_ff  <= '0;
            vec_ff  <= '0;
            slot_ff <= '0;
            byte_ff <= '0;
            char_ff <= '0;
         end else begin
            mode_ff <= mode_in;
            int_ff  <= int_in;
            vec_ff  <= vec_in;
            slot_ff <= slot_in;
            byte_ff <= byte_in;
            char_ff <= char_in;
         end
      end
   end

   // Fit the counters to the result fields
   assign slot_wide = {{OUT_SLOT_W{1'b0}}, slot_in};
   assign byte_wide = {{OUT_BYTE_W{1'b0}}, byte_in};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && act.is_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && act.is_end) begin
         rsp_int_ff  <= int_in;
         rsp_vec_ff  <= vec_in;
         rsp_slot_ff <= slot_wide[OUT_SLOT_W-1:0];
         rsp_byte_ff <= byte_wide[OUT_BYTE_W-1:0];
         rsp_char_ff <= char_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.int_regs    = rsp_int_ff;
   assign rsp_port.vec_regs    = rsp_vec_ff;
   assign rsp_port.stack_slots = rsp_slot_ff;
   assign rsp_port.extra_bytes = rsp_byte_ff;
   assign rsp_port.chars_used  = rsp_char_ff;

   // A NUL always closes the signature and raises a result
   a_nul_ends: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_port.ch == CH_NUL) |=> rsp_valid_ff && (char_ff == '0)
                                              && (mode_ff == MODE_NORMAL))
      else $error("NUL did not end the signature");

   // Slot count never drops within a signature
   a_slot_grows: assert property (@(posedge clock) disable iff (reset)
      req_take && !act.is_end |=> slot_ff >= $past(slot_ff))
      else $error("stack slot count decreased");

   // A result is only raised by an ending word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && act.is_end))
      else $error("result raised without an ending word");

endmodule

@@ dv/cssc_checker.sv @@
`timescale 1ns / 100ps

// Watch all three channels, predict each signature summary and compare it
// with what the block returns.
module cssc_checker import cssc_pkg::*; #(
   parameter int SLOT_BITS = 10,
   parameter int BYTE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CH_W-1:0]       req_ch,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [REG_W-1:0]      rsp_int_regs,
   input  logic [REG_W-1:0]      rsp_vec_regs,
   input  logic [OUT_SLOT_W-1:0] rsp_stack_slots,
   input  logic [OUT_BYTE_W-1:0] rsp_extra_bytes,
   input  logic [CHAR_W-1:0]     rsp_chars_used,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    sig_pending
);

   typedef struct packed {
      logic [REG_W-1:0]      int_regs;
      logic [REG_W-1:0]      vec_regs;
      logic [OUT_SLOT_W-1:0] stack_slots;
      logic [OUT_BYTE_W-1:0] extra_bytes;
      logic [CHAR_W-1:0]     chars_used;
   } sig_counts_type;

   localparam logic [SLOT_BITS-1:0] SLOT_FULL = '1;
   localparam logic [BYTE_BITS-1:0] BYTE_FULL = '1;

   // Shadow of the parser state and of the limit registers
   mode_type             mode;
   logic [REG_W-1:0]     int_limit;
   logic [REG_W-1:0]     vec_limit;
   logic [REG_W-1:0]     int_used;
   logic [REG_W-1:0]     vec_used;
   logic [SLOT_BITS-1:0] slots;
   logic [BYTE_BITS-1:0] bytes_added;
   logic [CHAR_W-1:0]    chars_seen;
   sig_counts_type       counts_q[$];

   function automatic void clear_counts();
      mode        = MODE_NORMAL;
      int_used    = '0;
      vec_used    = '0;
      slots       = '0;
      bytes_added = '0;
      chars_seen  = '0;
   endfunction

   // Add stack slots, holding at the top
   function automatic void bump_slots(input int n);
      if (int'(slots) > int'(SLOT_FULL) - n) begin
         slots = SLOT_FULL;
      end else begin
         slots = slots + SLOT_BITS'(n);
      end
   endfunction

   function automatic void bump_bytes(input int n);
      if (longint'(bytes_added) + n > longint'(BYTE_FULL)) begin
         bytes_added = BYTE_FULL;
      end else begin
         bytes_added = bytes_added + BYTE_BITS'(n);
      end
   endfunction

   function automatic void grab_int_reg();
      if (int_used < int_limit) begin
         int_used = int_used + REG_W'(1);
      end else begin
         bump_slots(1);
      end
   endfunction

   // Size in bytes that a complex or vector prefix adds for the next letter
   function automatic int prefix_bytes(input bit is_vec, input logic [CH_W-1:0] c);
      case (c)
         "f":     return is_vec ? 4 : 8;
         "d":     return is_vec ? 8 : 16;
         "e":     return is_vec ? 12 : 32;
         "g":     return is_vec ? 16 : 32;
         "k":     return 4;
         default: return 0;
      endcase
   endfunction

   // Sort one argument letter seen in plain parsing
   function automatic void classify(input logic [CH_W-1:0] c);
      case (c)
         "a", "b", "c", "h", "s", "t", "w", "i", "j", "l", "m", "x", "y", "r": begin
            grab_int_reg();
         end
         CH_PTR: begin
            grab_int_reg();
            mode = MODE_AFTER_P;
         end
         "d", "f", "k": begin
            if (vec_used < vec_limit) begin
               vec_used = vec_used + REG_W'(1);
            end else begin
               bump_slots(1);
            end
         end
         "e", "g", "n", "o": begin
            if (vec_used < vec_limit) begin
               vec_used = vec_used + REG_W'(1);
            end else begin
               // align to an even slot, then take a pair
               if (slots[0]) bump_slots(1);
               bump_slots(2);
            end
         end
         CH_CPLX: mode = MODE_AFTER_C;
         CH_VEC:  mode = MODE_AFTER_G;
         default: ;
      endcase
   endfunction

   // Advance the parser by one word; return 1 when the signature ends
   function automatic bit absorb_char(input logic [CH_W-1:0] c);
      if (c == CH_NUL) return 1'b1;
      if (chars_seen != CHAR_MAX) chars_seen = chars_seen + CHAR_W'(1);
      case (mode)
         MODE_AFTER_P: begin
            if (c == CH_PTR) begin
               // stay on the pointer chain
            end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
               mode = MODE_NORMAL;
            end else if (c == CH_XSKIP) begin
               mode = MODE_SKIP;
            end else if (c == CH_RPAREN) begin
               return 1'b1;
            end else begin
               mode = MODE_NORMAL;
               classify(c);
            end
         end
         MODE_SKIP: begin
            if (c == CH_SEMI) mode = MODE_NORMAL;
         end
         MODE_AFTER_C: begin
            bump_bytes(prefix_bytes(1'b0, c));
            mode = MODE_NORMAL;
         end
         MODE_AFTER_G: begin
            bump_bytes(prefix_bytes(1'b1, c));
            mode = MODE_NORMAL;
         end
         default: begin
            if (c == CH_RPAREN) return 1'b1;
            classify(c);
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      sig_counts_type want;
      if (reset) begin
         int_limit   = INT_LIMIT_RST;
         vec_limit   = VEC_LIMIT_RST;
         clear_counts();
         counts_q.delete();
         fail_count  = 0;
         sig_pending = 0;
      end else begin
         // compare a returned summary with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (counts_q.size() == 0) begin
               $error("unexpected result word: int_regs %0d vec_regs %0d stack_slots %0d",
                      rsp_int_regs, rsp_vec_regs, rsp_stack_slots);
               fail_count++;
            end else begin
               want = counts_q.pop_front();
               check_field("int_regs", want.int_regs, rsp_int_regs);
               check_field("vec_regs", want.vec_regs, rsp_vec_regs);
               check_field("stack_slots", want.stack_slots, rsp_stack_slots);
               check_field("extra_bytes", want.extra_bytes, rsp_extra_bytes);
               check_field("chars_used", want.chars_used, rsp_chars_used);
            end
         end

         // predict on every accepted character word, with the limits before this edge
         if (req_valid && req_ready) begin
            if (absorb_char(req_ch)) begin
               want.int_regs    = int_used;
               want.vec_regs    = vec_used;
               want.stack_slots = OUT_SLOT_W'(slots);
               want.extra_bytes = OUT_BYTE_W'(bytes_added);
               want.chars_used  = chars_seen;
               counts_q.push_back(want);
               clear_counts();
            end
         end

         // update limits; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INT_LIMIT: int_limit = csr_data;
               REG_VEC_LIMIT: vec_limit = csr_data;
               default: ;
            endcase
         end

         sig_pending = counts_q.size();
      end
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import cssc_pkg::*;

   localparam int IDLE_PCT       = 19;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int ITEM_GOAL      = 1800;
   localparam int PHASES         = 8;
   localparam int SAT_RUN        = 520;

   // No register lives at this index
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'hF;

   logic clock;
   logic reset;
   int   fail_count;
   int   sig_pending;
   int   src_idle_pct;
   int   snk_idle_pct;
   bit   hold_rsp;
   int   words_sent;

   cssc_req_if req_if ();
   cssc_rsp_if rsp_if ();
   cssc_csr_if csr_if ();

   call_signature_slot_classifier_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   cssc_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_ch          (req_if.ch),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_int_regs    (rsp_if.int_regs),
      .rsp_vec_regs    (rsp_if.vec_regs),
      .rsp_stack_slots (rsp_if.stack_slots),
      .rsp_extra_bytes (rsp_if.extra_bytes),
      .rsp_chars_used  (rsp_if.chars_used),
      .csr_valid       (csr_if.valid),
      .csr_ready       (csr_if.ready),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .fail_count      (fail_count),
      .sig_pending     (sig_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random back-pressure, or a long hold when asked
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Abort when no channel moves a word for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(negedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [CH_W-1:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // Offer one character word and hold it until taken; called at a rising edge
   task automatic put_word(input logic [CH_W-1:0] c);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   task automatic put_text(input string s);
      foreach (s[i]) put_word(s[i]);
   endtask

   // Drop valid, wait for every predicted summary, then let the pipe drain
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (sig_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_word(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic apply_limits(input logic [REG_W-1:0] int_lim, input logic [REG_W-1:0] vec_lim,
                               input bit with_spare);
      if (with_spare) csr_word(REG_SPARE, CSR_DATA_W'($urandom));
      csr_word(REG_INT_LIMIT, int_lim);
      csr_word(REG_VEC_LIMIT, vec_lim);
      csr_if.valid <= 1'b0;
   endtask

   // One argument: plain letter, pointer chain, prefixed type or stray byte
   task automatic send_argument();
      logic [CH_W-1:0] junk;
      case ($urandom_range(0, 9))
         0, 1, 2: put_word(pick("abchstwijlmxyr"));
         3, 4:    put_word(pick("dfk"));
         5:       put_word(pick("egno"));
         6: begin
            put_word(CH_PTR);
            repeat ($urandom_range(0, 2)) put_word(CH_PTR);
            case ($urandom_range(0, 3))
               0: put_word(CH_LOW_A + CH_W'($urandom_range(0, 25)));
               1: begin
                  put_word(CH_XSKIP);
                  repeat ($urandom_range(0, 5)) begin
                     junk = CH_W'($urandom_range(1, 255));
                     put_word(junk == CH_SEMI ? CH_RPAREN : junk);
                  end
                  put_word(CH_SEMI);
               end
               2: ;
               default: put_word(pick("ABDQZ(*[0"));
            endcase
         end
         7:       begin put_word(CH_CPLX); put_word(pick("fdegkz")); end
         8:       begin put_word(CH_VEC);  put_word(pick("fdegkq")); end
         default: put_word(CH_W'($urandom_range(1, 255)));
      endcase
   endtask

   // Mostly well-formed signatures, some noise and some left open mid-prefix
   task automatic send_signature();
      int shape;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 12)) put_word(CH_W'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 4) != 0) put_word("(");
         repeat ($urandom_range(0, 12)) send_argument();
         if (shape == 1) begin
            case ($urandom_range(0, 2))
               0:       put_word(CH_CPLX);
               1:       put_word(CH_VEC);
               default: begin put_word(CH_PTR); put_word(CH_XSKIP); end
            endcase
         end
         put_word($urandom_range(0, 3) == 0 ? CH_NUL : CH_RPAREN);
      end
   endtask

   initial begin : stimulus
      int phase_goal;
      req_if.valid <= 1'b0;
      req_if.ch    <= CH_NUL;
      csr_if.valid <= 1'b0;
      csr_if.index <= REG_INT_LIMIT;
      csr_if.data  <= '0;
      reset        <= 1'b1;
      src_idle_pct = IDLE_PCT;
      snk_idle_pct = IDLE_PCT;
      hold_rsp     = 1'b0;
      words_sent   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: pointer chains, skip with a paren inside, prefixes, NUL after a prefix
      put_text("(PPcPX");
      put_word(8'hFF);
      put_text(");CeGke)");
      put_text("P)");
      put_word(CH_CPLX);
      put_word(CH_NUL);
      put_word(CH_NUL);
      put_text("GZP;)");
      settle();

      // Random signatures under several limit settings
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       apply_limits(4'd0, 4'd0, 1'b1);
            1:       apply_limits(4'd15, 4'd15, 1'b0);
            2:       apply_limits(4'd0, 4'd15, 1'b0);
            3:       apply_limits(4'd15, 4'd0, 1'b1);
            default: apply_limits(REG_W'($urandom), REG_W'($urandom), 1'b0);
         endcase
         // one phase with no idling on either side
         src_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         snk_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         // stall the result side while characters keep coming
         if (phase == 2) hold_rsp = 1'b1;
         phase_goal = words_sent + (ITEM_GOAL - SAT_RUN) / PHASES;
         while (words_sent < phase_goal) send_signature();
         put_word(CH_NUL);
         settle();
      end

      // One long signature: the slot count saturates, rounding at the top included
      apply_limits(4'd0, 4'd0, 1'b0);
      put_word("(");
      repeat (SAT_RUN) put_word("e");
      put_word(CH_RPAREN);
      settle();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
